// File: rtl/pgim_pkg.sv
`timescale 1ns / 1ps
package pgim_pkg;

  localparam int unsigned MaxDim = 1024;
  localparam int unsigned RegW   = 11;
  localparam int unsigned NodeW  = 32;
  localparam int unsigned IdxW   = 30;
  localparam int unsigned DivW   = 21;
  localparam int unsigned RemW   = DivW + 1;
  localparam int unsigned SmallN = 11;

  localparam logic [2:0] REG_MESH_X = 3'd0;
  localparam logic [2:0] REG_MESH_Y = 3'd1;
  localparam logic [2:0] REG_DATA_X = 3'd2;
  localparam logic [2:0] REG_DATA_Y = 3'd3;
  localparam logic [2:0] REG_DATA_Z = 3'd4;

  typedef struct packed {
    logic [RemW-1:0] r;
    logic            q;
  } step_t;

  function automatic logic [RegW-1:0] clamp_dim(input logic [RegW-1:0] v);
    logic [RegW-1:0] res;
    res = v;
    if (v == '0) begin
      res = RegW'(1);
    end else if (v > RegW'(MaxDim)) begin
      res = RegW'(MaxDim);
    end
    return res;
  endfunction

  function automatic step_t div_step(input logic [RemW-1:0] r, input logic b,
                                     input logic [DivW-1:0] d);
    logic [RemW-1:0] t;
    step_t           s;
    t = {r[RemW-2:0], b};
    if (t >= {1'b0, d}) begin
      s.r = t - {1'b0, d};
      s.q = 1'b1;
    end else begin
      s.r = t;
      s.q = 1'b0;
    end
    return s;
  endfunction

endpackage

// File: rtl/periodic_grid_index_map.sv
`timescale 1ns / 1ps
// Periodic grid index map.
// Takes one-based mesh node numbers on the input channel (in_valid_i /
// in_ready_o, node_number_i) and returns for each one a row-major index into
// a periodically repeated data grid on the output channel (out_valid_o /
// out_ready_i, data_index_o, bad_node_o). Node number zero gives bad_node_o
// high and index zero.
// Mesh and data grid sizes are set through the write port (cfg_we_i,
// cfg_index_i, cfg_data_i); values of zero read as one, values above 1024
// read as 1024. Write them while no beat is in flight.
// From input beat to output beat, each beat passes one input register,
// a 32-step restoring divider for the plane split, two parallel 32-step
// dividers for the z wrap and the row split, two parallel 11-step dividers
// for the y and x wraps, one multiply stage and one sum stage.
// Throughput is one beat per cycle; each divider step is one register stage.
// When the receiver stalls, the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated. Reset empties the pipeline and sets all size
// registers to one.
module periodic_grid_index_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pgim_pkg::NodeW-1:0]  node_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [pgim_pkg::IdxW-1:0]   data_index_o,
  output logic                        bad_node_o,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_index_i,
  input  logic [pgim_pkg::RegW-1:0]   cfg_data_i
);
  import pgim_pkg::*;

  localparam int unsigned NA = NodeW;
  localparam int unsigned NB = NodeW;
  localparam int unsigned NC = SmallN;

  logic [RegW-1:0] mx_q, my_q, dx_q, dy_q, dz_q;
  logic [RegW-1:0] row_q;
  logic [DivW-1:0] plane_q, dxdy_q;
  logic            en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mx_q <= RegW'(1);
      my_q <= RegW'(1);
      dx_q <= RegW'(1);
      dy_q <= RegW'(1);
      dz_q <= RegW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MESH_X: mx_q <= clamp_dim(cfg_data_i);
        REG_MESH_Y: my_q <= clamp_dim(cfg_data_i);
        REG_DATA_X: dx_q <= clamp_dim(cfg_data_i);
        REG_DATA_Y: dy_q <= clamp_dim(cfg_data_i);
        REG_DATA_Z: dz_q <= clamp_dim(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= mx_q + RegW'(1);
    plane_q <= DivW'(mx_q + RegW'(1)) * DivW'(my_q + RegW'(1));
    dxdy_q  <= DivW'(dx_q) * DivW'(dy_q);
  end

  logic out_v_q;
  assign en          = !out_v_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;

  // plane split
  logic            a_v_q [0:NA];
  logic            a_b_q [0:NA];
  logic [RemW-1:0] a_r_q [0:NA];
  logic [NodeW-1:0] a_n_q [0:NA];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q[0] <= 1'b0;
    end else if (en) begin
      a_v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_b_q[0] <= (node_number_i == '0);
      a_r_q[0] <= '0;
      a_n_q[0] <= node_number_i - NodeW'(1);
    end
  end

  genvar k;
  for (k = 0; k < NA; k++) begin : g_a
    step_t s;
    assign s = div_step(a_r_q[k], a_n_q[k][NodeW-1], plane_q);
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        a_v_q[k+1] <= 1'b0;
      end else if (en) begin
        a_v_q[k+1] <= a_v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_b_q[k+1] <= a_b_q[k];
        a_r_q[k+1] <= s.r;
        a_n_q[k+1] <= {a_n_q[k][NodeW-2:0], s.q};
      end
    end
  end

  // z wrap and row split
  logic             b_v_q  [1:NB];
  logic             b_b_q  [1:NB];
  logic [RemW-1:0]  bz_r_q [1:NB];
  logic [NodeW-1:0] bz_n_q [1:NB];
  logic [RemW-1:0]  by_r_q [1:NB];
  logic [NodeW-1:0] by_n_q [1:NB];

  for (k = 0; k < NB; k++) begin : g_b
    logic             v_in, b_in;
    logic [RemW-1:0]  zr_in, yr_in;
    logic [NodeW-1:0] zn_in, yn_in;
    step_t            sz, sy;
    if (k == 0) begin : g_src0
      assign v_in  = a_v_q[NA];
      assign b_in  = a_b_q[NA];
      assign zr_in = '0;
      assign zn_in = a_n_q[NA];
      assign yr_in = '0;
      assign yn_in = {{(NodeW-DivW){1'b0}}, a_r_q[NA][DivW-1:0]};
    end else begin : g_srcn
      assign v_in  = b_v_q[k];
      assign b_in  = b_b_q[k];
      assign zr_in = bz_r_q[k];
      assign zn_in = bz_n_q[k];
      assign yr_in = by_r_q[k];
      assign yn_in = by_n_q[k];
    end
    assign sz = div_step(zr_in, zn_in[NodeW-1], {{(DivW-RegW){1'b0}}, dz_q});
    assign sy = div_step(yr_in, yn_in[NodeW-1], {{(DivW-RegW){1'b0}}, row_q});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        b_v_q[k+1] <= 1'b0;
      end else if (en) begin
        b_v_q[k+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        b_b_q[k+1]  <= b_in;
        bz_r_q[k+1] <= sz.r;
        bz_n_q[k+1] <= {zn_in[NodeW-2:0], sz.q};
        by_r_q[k+1] <= sy.r;
        by_n_q[k+1] <= {yn_in[NodeW-2:0], sy.q};
      end
    end
  end

  // y and x wraps
  logic             c_v_q  [1:NC];
  logic             c_b_q  [1:NC];
  logic [RegW-1:0]  c_z_q  [1:NC];
  logic [RemW-1:0]  cy_r_q [1:NC];
  logic [SmallN-1:0] cy_n_q [1:NC];
  logic [RemW-1:0]  cx_r_q [1:NC];
  logic [SmallN-1:0] cx_n_q [1:NC];

  for (k = 0; k < NC; k++) begin : g_c
    logic              v_in, b_in;
    logic [RegW-1:0]   z_in;
    logic [RemW-1:0]   yr_in, xr_in;
    logic [SmallN-1:0] yn_in, xn_in;
    step_t             sy, sx;
    if (k == 0) begin : g_src0
      assign v_in  = b_v_q[NB];
      assign b_in  = b_b_q[NB];
      assign z_in  = bz_r_q[NB][RegW-1:0];
      assign yr_in = '0;
      assign yn_in = by_n_q[NB][SmallN-1:0];
      assign xr_in = '0;
      assign xn_in = by_r_q[NB][SmallN-1:0];
    end else begin : g_srcn
      assign v_in  = c_v_q[k];
      assign b_in  = c_b_q[k];
      assign z_in  = c_z_q[k];
      assign yr_in = cy_r_q[k];
      assign yn_in = cy_n_q[k];
      assign xr_in = cx_r_q[k];
      assign xn_in = cx_n_q[k];
    end
    assign sy = div_step(yr_in, yn_in[SmallN-1], {{(DivW-RegW){1'b0}}, dy_q});
    assign sx = div_step(xr_in, xn_in[SmallN-1], {{(DivW-RegW){1'b0}}, dx_q});
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_v_q[k+1] <= 1'b0;
      end else if (en) begin
        c_v_q[k+1] <= v_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        c_b_q[k+1]  <= b_in;
        c_z_q[k+1]  <= z_in;
        cy_r_q[k+1] <= sy.r;
        cy_n_q[k+1] <= {yn_in[SmallN-2:0], sy.q};
        cx_r_q[k+1] <= sx.r;
        cx_n_q[k+1] <= {xn_in[SmallN-2:0], sx.q};
      end
    end
  end

  // multiply and sum
  logic              m_v_q, m_b_q;
  logic [IdxW-1:0]   m_p1_q;
  logic [2*RegW-1:0] m_p2_q;
  logic [RegW-1:0]   m_x_q;
  logic [IdxW-1:0]   idx_q;
  logic              bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      m_v_q   <= c_v_q[NC];
      out_v_q <= m_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_b_q  <= c_b_q[NC];
      m_p1_q <= IdxW'(c_z_q[NC]) * IdxW'(dxdy_q);
      m_p2_q <= {{RegW{1'b0}}, cy_r_q[NC][RegW-1:0]} * {{RegW{1'b0}}, dx_q};
      m_x_q  <= cx_r_q[NC][RegW-1:0];
      bad_q  <= m_b_q;
      idx_q  <= m_b_q ? '0 : (m_p1_q + IdxW'(m_p2_q) + IdxW'(m_x_q));
    end
  end

  assign data_index_o = idx_q;
  assign bad_node_o   = bad_q;

endmodule

// File: tb/sv/periodic_grid_index_map_tb.sv
`timescale 1ns / 1ps
module periodic_grid_index_map_tb;
  import pgim_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [NodeW-1:0]    node_number_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [IdxW-1:0]     data_index_o;
  logic                bad_node_o;
  logic                cfg_we_i;
  logic [2:0]          cfg_index_i;
  logic [RegW-1:0]     cfg_data_i;

  typedef struct {
    logic [IdxW-1:0] idx;
    logic            bad;
  } grid_hit_t;

  localparam int unsigned Latency = 78;
  localparam int unsigned CycleLimit = 400000;

  logic [RegW-1:0] size_q [5];
  grid_hit_t       expected_hits [$];
  int unsigned     mismatch_cnt;
  int unsigned     hit_cnt;
  int unsigned     node_cnt;
  int unsigned     cycle_cnt;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;

  periodic_grid_index_map DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(input logic [RegW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return v;
  endfunction

  function automatic grid_hit_t map_node(input logic [NodeW-1:0] node);
    grid_hit_t    h;
    longint unsigned mx, my, dx, dy, dz, row, plane, off, rem, iz, iy, ix;
    mx = eff_dim(size_q[REG_MESH_X]);
    my = eff_dim(size_q[REG_MESH_Y]);
    dx = eff_dim(size_q[REG_DATA_X]);
    dy = eff_dim(size_q[REG_DATA_Y]);
    dz = eff_dim(size_q[REG_DATA_Z]);
    h.idx = '0;
    h.bad = 1'b1;
    if (node != 0) begin
      row   = mx + 1;
      plane = row * (my + 1);
      off   = node - 1;
      iz    = (off / plane) % dz;
      rem   = off % plane;
      iy    = (rem / row) % dy;
      ix    = (rem % row) % dx;
      h.idx = IdxW'(iz * (dx * dy) + iy * dx + ix);
      h.bad = 1'b0;
    end
    return h;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[periodic_grid_index_map] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    grid_hit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      hit_cnt <= hit_cnt + 1;
      if (expected_hits.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10) $display("unexpected beat idx=%0d bad=%0b",
                                         data_index_o, bad_node_o);
      end else begin
        want = expected_hits.pop_front();
        if (want.idx !== data_index_o || want.bad !== bad_node_o) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected idx=%0d bad=%0b, got idx=%0d bad=%0b",
                     want.idx, want.bad, data_index_o, bad_node_o);
        end
      end
    end
  end

  task automatic send_node(input logic [NodeW-1:0] node);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    node_number_i <= node;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_hits.push_back(map_node(node));
    node_cnt++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_size(input logic [2:0] index, input logic [RegW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index <= REG_DATA_Z) size_q[index] = value;
    @(posedge clk_i);
  endtask

  task automatic set_sizes(input logic [RegW-1:0] mx, my, dx, dy, dz);
    drain();
    write_size(REG_MESH_X, mx);
    write_size(REG_MESH_Y, my);
    write_size(REG_DATA_X, dx);
    write_size(REG_DATA_Y, dy);
    write_size(REG_DATA_Z, dz);
  endtask

  task automatic test_directed;
    set_sizes(4, 3, 3, 2, 2);
    send_node('0);
    send_node(1);
    send_node(2);
    send_node(6);
    send_node(21);
    send_node('1);
    send_node(32'h8000_0000);
    send_node(32'h5555_5555);
    send_node(32'hAAAA_AAAA);
    set_sizes(0, 11'h7FF, 1025, 0, 2047);
    write_size(3'd5, 7);
    write_size(3'd7, 9);
    send_node(1);
    send_node(2050);
    send_node('1);
    send_node('0);
    set_sizes(1024, 1024, 1024, 1024, 1024);
    send_node(1);
    send_node(1025);
    send_node(1026);
    send_node(1050626);
    send_node('1);
    send_node(32'h7FFF_FFFF);
  endtask

  task automatic test_random(input int unsigned n);
    logic [NodeW-1:0] node;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        if ($urandom_range(3) == 0)
          set_sizes(RegW'($urandom), RegW'($urandom), RegW'($urandom),
                    RegW'($urandom), RegW'($urandom));
        else
          set_sizes(RegW'($urandom_range(1, 40)), RegW'($urandom_range(1, 40)),
                    RegW'($urandom_range(1, 12)), RegW'($urandom_range(1, 12)),
                    RegW'($urandom_range(1, 12)));
      end
      case ($urandom_range(3))
        0: node = $urandom;
        1: node = $urandom_range(0, 5000);
        2: node = $urandom_range(0, 200);
        default: node = $urandom_range(0, 3) == 0 ? '0 : ~NodeW'($urandom_range(0, 99));
      endcase
      send_node(node);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    node_number_i = '0;
    out_ready_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatch_cnt  = 0;
    hit_cnt       = 0;
    node_cnt      = 0;
    cycle_cnt     = 0;
    for (int i = 0; i < 5; i++) size_q[i] = 1;
    send_idle_pct = 27;
    recv_idle_pct = 76;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    send_idle_pct = 76;
    recv_idle_pct = 27;
    test_random(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(330);
    drain();
    $display("sent %0d node numbers, checked %0d indices across many grid sizes",
             node_cnt, hit_cnt);
    if (mismatch_cnt == 0 && expected_hits.size() == 0) begin
      $display("[periodic_grid_index_map] OK");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("[periodic_grid_index_map] ERROR");
    end
    $finish;
  end

endmodule
